FILE: design/cvm_pkg.sv
// Package with the shared datapath types, widths and constant tables of the CORDIC magnitude block.
`default_nettype none

package cvm_pkg;

  // Fixed-point format and iteration count of the rotation chain.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ITERATIONS = 16;
  localparam int unsigned ITER_W     = $clog2(ITERATIONS);

  // Field widths of the ports.
  localparam int unsigned IN_W  = 30;
  localparam int unsigned MAG_W = 31;
  localparam int unsigned ANG_W = 18;

  // The x and y paths carry three guard bits above the input so the gain growth
  // of about 1.65 on a vector of length up to sqrt(2) never wraps, plus a sign.
  localparam int unsigned XY_W = IN_W + 4;

  // Gain correction, the product of 1/sqrt(1+4^-i) over all steps, in Q.FRAC_BITS.
  localparam int unsigned K_W = 16;
  localparam logic [K_W-1:0] GAIN_K = 16'd39797;

  // Largest magnitude that fits the output field.
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  // Operand of one micro-rotation as it travels along the chain.
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  // atan(2^-i) in Q.FRAC_BITS, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    unique case (idx)
      4'd0:    val = 18'sd51472;
      4'd1:    val = 18'sd30386;
      4'd2:    val = 18'sd16055;
      4'd3:    val = 18'sd8150;
      4'd4:    val = 18'sd4091;
      4'd5:    val = 18'sd2047;
      4'd6:    val = 18'sd1024;
      4'd7:    val = 18'sd512;
      4'd8:    val = 18'sd256;
      4'd9:    val = 18'sd128;
      4'd10:   val = 18'sd64;
      4'd11:   val = 18'sd32;
      4'd12:   val = 18'sd16;
      4'd13:   val = 18'sd8;
      4'd14:   val = 18'sd4;
      4'd15:   val = 18'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/cvm_cell.sv
// One CORDIC vectoring micro-rotation stage with its own request register.
`default_nettype none

module cvm_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire cvm_pkg::vec_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output cvm_pkg::vec_t     out_data_o
);

  localparam int unsigned IdxW = cvm_pkg::ITER_W;

  logic                                   valid_q, valid_d;
  cvm_pkg::vec_t                          data_q, data_d;
  logic signed [cvm_pkg::XY_W-1:0]        x_sh, y_sh;
  logic signed [cvm_pkg::ANG_W-1:0]       atan_val;
  logic                                   take;

  // The stage takes a new request whenever its slot is empty or is being drained.
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  assign x_sh     = in_data_i.x >>> STAGE;
  assign y_sh     = in_data_i.y >>> STAGE;
  assign atan_val = cvm_pkg::atan_lut(IdxW'(STAGE));

  always_comb begin
    // A non-negative y rotates clockwise, a negative y counter-clockwise.
    if (in_data_i.y[cvm_pkg::XY_W-1]) begin
      data_d.x = in_data_i.x - y_sh;
      data_d.y = in_data_i.y + x_sh;
      data_d.z = in_data_i.z - atan_val;
    end else begin
      data_d.x = in_data_i.x + y_sh;
      data_d.y = in_data_i.y - x_sh;
      data_d.z = in_data_i.z + atan_val;
    end
  end

  always_comb begin
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/cvm_gain.sv
// Gain correction stage: scales x by the CORDIC gain, saturates, and holds the result.
`default_nettype none

module cvm_gain (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cvm_pkg::vec_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cvm_pkg::MAG_W-1:0]          magnitude_o,
  output logic signed [cvm_pkg::ANG_W-1:0]   angle_o
);

  localparam int unsigned XPosW = cvm_pkg::XY_W - 1;
  localparam int unsigned ProdW = XPosW + cvm_pkg::K_W;
  localparam int unsigned ShW   = ProdW - cvm_pkg::FRAC_BITS;

  // Product register.
  logic                              prod_valid_q, prod_valid_d;
  logic [ProdW-1:0]                  prod_q, prod_d;
  logic signed [cvm_pkg::ANG_W-1:0]  prod_ang_q;
  logic                              prod_ready, prod_take;
  logic [XPosW-1:0]                  x_pos;

  // Output register.
  logic                              out_valid_q, out_valid_d;
  logic [cvm_pkg::MAG_W-1:0]         mag_q, mag_d;
  logic signed [cvm_pkg::ANG_W-1:0]  ang_q;
  logic                              out_take;
  logic [ShW-1:0]                    prod_sh;

  assign in_ready_o = !prod_valid_q || prod_ready;
  assign prod_take  = in_valid_i && in_ready_o;

  // A negative x is clamped to zero before scaling.
  assign x_pos  = in_data_i.x[cvm_pkg::XY_W-1] ? '0 : in_data_i.x[XPosW-1:0];
  assign prod_d = ProdW'(x_pos) * ProdW'(cvm_pkg::GAIN_K);

  assign prod_valid_d = in_ready_o ? in_valid_i : prod_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_take) begin
      prod_q     <= prod_d;
      prod_ang_q <= in_data_i.z;
    end
  end

  assign prod_ready = !out_valid_q || out_ready_i;
  assign out_take   = prod_valid_q && prod_ready;

  assign prod_sh = prod_q[ProdW-1:cvm_pkg::FRAC_BITS];

  always_comb begin
    if (|prod_sh[ShW-1:cvm_pkg::MAG_W]) begin
      mag_d = cvm_pkg::MAG_MAX;
    end else begin
      mag_d = prod_sh[cvm_pkg::MAG_W-1:0];
    end
  end

  assign out_valid_d = prod_ready ? prod_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      mag_q <= mag_d;
      ang_q <= prod_ang_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign angle_o     = ang_q;

endmodule

`default_nettype wire

FILE: design/cordic_vector_magnitude.sv
// Top level of the pipelined circular CORDIC vectoring unit (magnitude and angle).
`default_nettype none

// Channel   Handshake                    Payload
// input     in_valid_i / in_ready_o      vec_x_i[29:0], vec_y_i[29:0]
// output    out_valid_o / out_ready_i    magnitude_o[30:0], angle_o[17:0] (signed)
//
// Every request passes through 16 rotation cells, one per CORDIC step, then a
// multiply stage and an output stage, each registered; the result is presented
// from the output register and leaves at an edge with out_ready_i high.
// The chain takes one request per cycle when not stalled.
// Reset clears only the valid flags of the stages; data registers load freely.
// Each stage holds its request only while the next one is full and stalled, so
// bubbles close up and new requests keep entering while a result waits.

module cordic_vector_magnitude (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cvm_pkg::IN_W-1:0]     vec_x_i,
  input  wire logic [cvm_pkg::IN_W-1:0]     vec_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cvm_pkg::MAG_W-1:0]         magnitude_o,
  output logic signed [cvm_pkg::ANG_W-1:0]  angle_o
);

  localparam int unsigned Iters = cvm_pkg::ITERATIONS;

  // Links between neighboring cells; link 0 is the input port, link Iters
  // feeds the gain stage.
  logic          link_valid [Iters+1];
  logic          link_ready [Iters+1];
  cvm_pkg::vec_t link_data  [Iters+1];

  // The inputs are zero-extended into the signed datapath; the angle starts at zero.
  assign link_valid[0]  = in_valid_i;
  assign in_ready_o     = link_ready[0];
  assign link_data[0].x = signed'(cvm_pkg::XY_W'(vec_x_i));
  assign link_data[0].y = signed'(cvm_pkg::XY_W'(vec_y_i));
  assign link_data[0].z = '0;

  for (genvar g = 0; g < Iters; g++) begin : g_cell
    cvm_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[g]),
      .in_ready_o  (link_ready[g]),
      .in_data_i   (link_data[g]),
      .out_valid_o (link_valid[g+1]),
      .out_ready_i (link_ready[g+1]),
      .out_data_o  (link_data[g+1])
    );
  end

  // Final scaling by the CORDIC gain and the output register.
  cvm_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (link_valid[Iters]),
    .in_ready_o  (link_ready[Iters]),
    .in_data_i   (link_data[Iters]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_o)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the pipelined CORDIC vector magnitude and angle unit.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IN_W  = cvm_pkg::IN_W;
  localparam int unsigned MAG_W = cvm_pkg::MAG_W;
  localparam int unsigned ANG_W = cvm_pkg::ANG_W;

  // The predictor keeps its own copy of the format, step count and gain, so a
  // wrong constant in the design package shows up as a mismatch.
  localparam int     FRAC        = 16;
  localparam int     STEPS       = 16;
  localparam longint GAIN_Q16    = 39797;
  localparam longint MAG_LIMIT   = 64'h7FFF_FFFF;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } polar_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [IN_W-1:0]          vec_x_i;
  logic [IN_W-1:0]          vec_y_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [MAG_W-1:0]         magnitude_o;
  logic signed [ANG_W-1:0]  angle_o;

  // Results predicted for accepted requests, oldest first.
  polar_t pending_results [$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned vectors_sent;
  int unsigned results_checked;
  int unsigned stall_left;
  bit          no_idle;

  cordic_vector_magnitude u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung pipeline or a lost handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Rounded atan(2^-i) in Q16, one entry per micro-rotation.
  function automatic longint atan_step_q16(input int i);
    longint val;
    case (i)
      0:       val = 51472;
      1:       val = 30386;
      2:       val = 16055;
      3:       val = 8150;
      4:       val = 4091;
      5:       val = 2047;
      6:       val = 1024;
      7:       val = 512;
      8:       val = 256;
      9:       val = 128;
      10:      val = 64;
      11:      val = 32;
      12:      val = 16;
      13:      val = 8;
      14:      val = 4;
      15:      val = 2;
      default: val = 0;
    endcase
    return val;
  endfunction

  // Vectoring-mode CORDIC on 64-bit signed values. The sign of y picks the
  // rotation direction at every step; shifts are arithmetic, so negative y
  // rounds toward minus infinity. x is then scaled by the gain correction,
  // floored and saturated, and z is truncated to the angle field.
  function automatic polar_t predict_polar(input logic [IN_W-1:0] vx,
                                           input logic [IN_W-1:0] vy);
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      ny;
    logic [63:0] prod;
    polar_t      res;
    x = longint'(vx);
    y = longint'(vy);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - atan_step_q16(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + atan_step_q16(i);
      end
      x = nx;
      y = ny;
    end
    if (x < 0) begin
      x = 0;
    end
    prod = x * GAIN_Q16;
    prod = prod >> FRAC;
    if (prod > MAG_LIMIT) begin
      prod = MAG_LIMIT;
    end
    res.mag = prod[MAG_W-1:0];
    res.ang = z[ANG_W-1:0];
    return res;
  endfunction

  // Presents one request after a random gap and holds it until accepted. The
  // gap drops valid at a falling edge and raises it at a later one, so valid
  // never toggles twice in one time step. The expectation is queued at the
  // accepting edge.
  task automatic send_vector(input logic [IN_W-1:0] vx, input logic [IN_W-1:0] vy);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_x_i    <= vx;
    vec_y_i    <= vy;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_results.push_back(predict_polar(vx, vy));
    vectors_sent++;
  endtask

  // Stops sending and waits until every queued result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Axis-aligned, diagonal, extreme and bit-pattern vectors. The zero vector
  // must give magnitude 0 and the full sum of the atan table as its angle.
  task automatic test_corner_vectors();
    logic [IN_W-1:0] full;
    full = '1;
    send_vector('0, '0);
    send_vector(full, '0);
    send_vector('0, full);
    send_vector(full, full);
    send_vector(30'd1, '0);
    send_vector('0, 30'd1);
    send_vector(30'd1, 30'd1);
    send_vector(30'h0001_0000, '0);
    send_vector('0, 30'h0001_0000);
    send_vector(30'h0001_0000, 30'h0001_0000);
    send_vector(30'h0003_0000, 30'h0004_0000);
    send_vector(30'h0004_0000, 30'h0003_0000);
    send_vector(30'h2AAA_AAAA, 30'h1555_5555);
    send_vector(30'h1555_5555, 30'h2AAA_AAAA);
    send_vector(full, 30'd1);
    send_vector(30'd1, full);
    send_vector(30'h2000_0000, 30'h2000_0000);
    send_vector(30'h2000_0000, 30'h1FFF_FFFF);
    send_vector(full, full - 30'd1);
    // Let the pipeline run empty before the random phases start.
    drain_results();
  endtask

  // Uniform vectors over the whole input range.
  task automatic test_random_full_range(input int unsigned count);
    repeat (count) begin
      send_vector(IN_W'($urandom), IN_W'($urandom));
    end
  endtask

  // Vectors at random scales, so rounding of the shifted terms matters.
  task automatic test_small_scales(input int unsigned count);
    logic [31:0] xlim;
    logic [31:0] ylim;
    repeat (count) begin
      xlim = (32'd1 << $urandom_range(0, IN_W)) - 32'd1;
      ylim = (32'd1 << $urandom_range(0, IN_W)) - 32'd1;
      send_vector(IN_W'($urandom & xlim), IN_W'($urandom & ylim));
    end
  endtask

  // One component far smaller than the other, for angles near 0 and pi/2.
  task automatic test_near_axis(input int unsigned count);
    logic [IN_W-1:0] big;
    logic [IN_W-1:0] tiny;
    repeat (count) begin
      big  = IN_W'($urandom);
      tiny = big >> $urandom_range(8, IN_W);
      tiny = tiny ^ IN_W'($urandom_range(0, 3));
      if ($urandom_range(0, 1) != 0) begin
        send_vector(big, tiny);
      end else begin
        send_vector(tiny, big);
      end
    end
  endtask

  // Full-rate stretch: no gaps on the input and no stalls on the output.
  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    test_random_full_range(count);
    no_idle = 1'b0;
  endtask

  // Output side: after each accepted result, hold ready low for a random
  // number of cycles, then keep it high until the next result is taken.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    polar_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      stall_left <= no_idle ? 0 : $urandom_range(0, 10);
      if (pending_results.size() == 0) begin
        $error("unexpected result: magnitude %0d angle %0d", magnitude_o, angle_o);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (magnitude_o !== exp_res.mag) begin
          $error("magnitude: expected %0d, got %0d", exp_res.mag, magnitude_o);
          mismatch_count++;
        end
        if (angle_o !== exp_res.ang) begin
          $error("angle: expected %0d, got %0d", exp_res.ang, angle_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    vec_x_i         = '0;
    vec_y_i         = '0;
    out_ready_i     = 1'b0;
    cycle_count     = 0;
    mismatch_count  = 0;
    vectors_sent    = 0;
    results_checked = 0;
    stall_left      = 0;
    no_idle         = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_vectors();
    test_random_full_range(250);
    test_small_scales(100);
    test_near_axis(100);
    test_back_to_back(100);

    drain_results();
    // Anything that comes out now has no request behind it.
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d vectors: corners, full range, small scales, near-axis, full rate.",
             vectors_sent);
    $display("Compared %0d results with %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cvm_pkg.sv
design/cvm_cell.sv
design/cvm_gain.sv
design/cordic_vector_magnitude.sv
sim/testbench.sv
